[sv/scan_elevator_disk_scheduler_macros.svh]
// Assertion macros for the SCAN elevator disk scheduler.
`ifndef SCAN_ELEVATOR_DISK_SCHEDULER_MACROS_SVH
`define SCAN_ELEVATOR_DISK_SCHEDULER_MACROS_SVH

// Check cons in the same cycle whenever ante holds.
`define SED_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante holds.
`define SED_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/sed_pkg.sv]
// Shared types and constants of the SCAN elevator disk scheduler.
`timescale 1ns / 1ps
package sed_pkg;

    localparam int CYL_W      = 10;
    localparam int MOVE_W     = 11;
    localparam int SEEK_W     = 15;
    localparam int COST_W     = 4;
    localparam int CFG_W      = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = 1;
    localparam int FIFO_CNT_W = 2;

    localparam logic [MOVE_W-1:0] MOVE_MAX    = 11'h7FF;
    localparam logic [CYL_W-1:0]  RESET_START = 10'd100;
    localparam logic [COST_W-1:0] RESET_COST  = 4'd5;

    localparam logic [CFG_IDX_W-1:0] REG_START_CYL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COST      = 1'b1;

    typedef enum logic {
        CMD_LOAD,
        CMD_SERVE
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [CYL_W-1:0]  cyl;
    } t_cmd;

    typedef struct packed {
        logic              ins;
        logic              clr;
        logic [CYL_W-1:0]  cyl;
    } t_store_ctl;

    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last;
        logic [CYL_W-1:0]  cyl;
    } t_stop;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic [CYL_W-1:0]  cyl;
        logic [MOVE_W-1:0] move;
    } t_move_stage;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DOWN,
        ST_TURN,
        ST_UP
    } t_bstate;

endpackage

[sv/scan_elevator_disk_scheduler.sv]
// SCAN elevator disk scheduler top level.
// Loading: one request per cycle while busy is low, through a two-item queue; busy rises only while it is full.
// Service: after the batch_end item, the requests at or below the start cylinder are walked
// one per cycle, then one stop per cycle follows, receiver never stalls.
// Reset: start cylinder 100, cost 5, queue and sorted store empty; no clearing pass.
`timescale 1ns / 1ps
`include "scan_elevator_disk_scheduler_macros.svh"
module scan_elevator_disk_scheduler #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [sed_pkg::CYL_W-1:0]     i_request_cylinder,
    input  logic                          i_batch_end,
    input  logic                          i_cfg_we,
    input  logic [sed_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sed_pkg::CFG_W-1:0]     i_cfg_wdata,
    output logic                          o_valid,
    output logic [sed_pkg::CYL_W-1:0]     o_served_cylinder,
    output logic [sed_pkg::MOVE_W-1:0]    o_total_movement,
    output logic [sed_pkg::SEEK_W-1:0]    o_seek_time,
    output logic                          o_final_stop
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // configuration registers
    logic [sed_pkg::CYL_W-1:0]  r_start_cyl;
    logic [sed_pkg::COST_W-1:0] r_cost;

    // front to back queue
    logic                       fifo_full;
    logic                       cmd_valid;
    sed_pkg::t_cmd              cmd;
    logic                       cmd_pop;
    logic                       push;

    // back to store
    sed_pkg::t_store_ctl        store_ctl;
    logic [CNT_W-1:0]           rd_idx;
    logic [sed_pkg::CYL_W-1:0]  rd_cyl;
    logic [CNT_W-1:0]           count;

    // Config writes land directly; the port has no read-back. The user must issue writes
    // only while no batch is in service, so the back end sees stable values; the block does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_cyl <= sed_pkg::RESET_START;
            r_cost      <= sed_pkg::RESET_COST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sed_pkg::REG_START_CYL: r_start_cyl <= i_cfg_wdata;
                sed_pkg::REG_COST:      r_cost      <= i_cfg_wdata[sed_pkg::COST_W-1:0];
                default:                r_start_cyl <= r_start_cyl;
            endcase
        end
    end

    // An item is taken whenever the queue has room, also during service:
    // the next batch's requests wait in the queue until the sweep finishes.
    assign push = start && !busy;
    assign busy = fifo_full;

    sed_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_cyl       (i_request_cylinder),
        .i_batch_end (i_batch_end),
        .i_pop       (cmd_pop),
        .o_full      (fifo_full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    // Sorted store: every request is inserted by shifting the larger held entries
    // up; a request arriving with the store full is dropped.
    sed_store #(
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (store_ctl),
        .i_rd_idx (rd_idx),
        .o_rd_cyl (rd_cyl),
        .o_count  (count)
    );

    // Back end: find the split point at the start cylinder, sweep down,
    // stop at cylinder 0, sweep up, then empty the store. Stops pass through
    // a movement stage and a seek multiply stage before reaching the outputs.
    sed_back #(
        .DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd_valid       (cmd_valid),
        .i_cmd             (cmd),
        .o_pop             (cmd_pop),
        .o_store_ctl       (store_ctl),
        .o_rd_idx          (rd_idx),
        .i_rd_cyl          (rd_cyl),
        .i_count           (count),
        .i_start_cyl       (r_start_cyl),
        .i_cost            (r_cost),
        .o_valid           (o_valid),
        .o_served_cylinder (o_served_cylinder),
        .o_total_movement  (o_total_movement),
        .o_seek_time       (o_seek_time),
        .o_final_stop      (o_final_stop)
    );

    // Batches never run back to back: after the final stop a gap follows.
    `SED_ASSERT_NEXT(a_gap_after_final, o_valid && o_final_stop, !o_valid, "stop right after final stop")
    // Within one batch the running movement never falls.
    `SED_ASSERT_SAME(a_move_rises, o_valid && $past(o_valid) && !$past(o_final_stop), o_total_movement >= $past(o_total_movement), "total movement fell within a batch")
    // Seek time tracks movement: no movement, no seek time.
    `SED_ASSERT_SAME(a_seek_zero, o_valid && (o_total_movement == '0), o_seek_time == '0, "seek time without movement")

endmodule

[sv/sed_front.sv]
// Front end: accepts items, tags them load or serve, and queues them.
`timescale 1ns / 1ps
module sed_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  logic [sed_pkg::CYL_W-1:0] i_cyl,
    input  logic                    i_batch_end,
    input  logic                    i_pop,
    output logic                    o_full,
    output logic                    o_cmd_valid,
    output sed_pkg::t_cmd           o_cmd
);

    sed_pkg::t_cmd                     r_mem [sed_pkg::FIFO_DEPTH];
    logic [sed_pkg::FIFO_PTR_W-1:0]    r_wr_ptr;
    logic [sed_pkg::FIFO_PTR_W-1:0]    r_rd_ptr;
    logic [sed_pkg::FIFO_CNT_W-1:0]    r_cnt;
    logic [sed_pkg::FIFO_CNT_W-1:0]    n_cnt;
    sed_pkg::t_cmd                     w_cmd;

    // classify the item
    always_comb begin
        w_cmd.cyl  = i_cyl;
        w_cmd.kind = i_batch_end ? sed_pkg::CMD_SERVE : sed_pkg::CMD_LOAD;
    end

    always_comb begin
        unique case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= w_cmd;
        end
    end

    assign o_full      = (r_cnt == sed_pkg::FIFO_CNT_W'(sed_pkg::FIFO_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_mem[r_rd_ptr];

endmodule

[sv/sed_store.sv]
// Sorted request store: a row of cells that shifts to insert in rising order.
`timescale 1ns / 1ps
module sed_store #(
    parameter  int DEPTH = 32,
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sed_pkg::t_store_ctl       i_ctl,
    input  logic [CNT_W-1:0]          i_rd_idx,
    output logic [sed_pkg::CYL_W-1:0] o_rd_cyl,
    output logic [CNT_W-1:0]          o_count
);

    logic [sed_pkg::CYL_W-1:0] r_ent [DEPTH];
    logic [sed_pkg::CYL_W-1:0] shift_src [DEPTH];
    logic [DEPTH-1:0]          gt;
    logic [DEPTH-1:0]          wr;
    logic [CNT_W-1:0]          r_count;
    logic                      full;

    assign full = (r_count == CNT_W'(DEPTH));

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        // held entries above the new value move up one place
        assign gt[g] = (CNT_W'(g) < r_count) && (r_ent[g] > i_ctl.cyl);
        if (g == 0) begin : g_first
            assign shift_src[g] = i_ctl.cyl;
        end else begin : g_rest
            assign shift_src[g] = gt[g-1] ? r_ent[g-1] : i_ctl.cyl;
        end
        assign wr[g] = i_ctl.ins && !full && (gt[g] || (CNT_W'(g) == r_count));
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (wr[i]) begin
                r_ent[i] <= shift_src[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.clr) begin
            r_count <= '0;
        end else if (i_ctl.ins && !full) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    always_comb begin
        o_rd_cyl = '0;
        if (i_rd_idx < CNT_W'(DEPTH)) begin
            o_rd_cyl = r_ent[i_rd_idx[IDX_W-1:0]];
        end
    end

    assign o_count = r_count;

endmodule

[sv/sed_back.sv]
// Back end: service sequencer, head movement tracking and seek time output.
`timescale 1ns / 1ps
module sed_back #(
    parameter  int DEPTH = 32,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmd_valid,
    input  sed_pkg::t_cmd              i_cmd,
    output logic                       o_pop,
    output sed_pkg::t_store_ctl        o_store_ctl,
    output logic [CNT_W-1:0]           o_rd_idx,
    input  logic [sed_pkg::CYL_W-1:0]  i_rd_cyl,
    input  logic [CNT_W-1:0]           i_count,
    input  logic [sed_pkg::CYL_W-1:0]  i_start_cyl,
    input  logic [sed_pkg::COST_W-1:0] i_cost,
    output logic                       o_valid,
    output logic [sed_pkg::CYL_W-1:0]  o_served_cylinder,
    output logic [sed_pkg::MOVE_W-1:0] o_total_movement,
    output logic [sed_pkg::SEEK_W-1:0] o_seek_time,
    output logic                       o_final_stop
);

    sed_pkg::t_bstate          r_state, n_state;
    logic [CNT_W-1:0]          r_ptr, n_ptr;
    logic [CNT_W-1:0]          r_below, n_below;
    logic                      r_first, n_first;
    sed_pkg::t_stop            r_stop, n_stop;
    logic [sed_pkg::CYL_W-1:0]  r_head;
    logic [sed_pkg::MOVE_W-1:0] r_move;
    sed_pkg::t_move_stage      r_mv;

    logic [sed_pkg::CYL_W-1:0]  base_head;
    logic [sed_pkg::MOVE_W-1:0] base_move;
    logic [sed_pkg::CYL_W-1:0]  hop_len;
    logic [sed_pkg::MOVE_W:0]   move_sum;
    logic [sed_pkg::MOVE_W-1:0] move_sat;
    logic [sed_pkg::SEEK_W-1:0] seek_prod;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_below     = r_below;
        n_first     = r_first;
        n_stop      = '0;
        o_pop       = 1'b0;
        o_store_ctl = '0;
        o_rd_idx    = r_ptr;
        unique case (r_state)
            sed_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop           = 1'b1;
                    o_store_ctl.ins = 1'b1;
                    o_store_ctl.cyl = i_cmd.cyl;
                    if (i_cmd.kind == sed_pkg::CMD_SERVE) begin
                        n_state = sed_pkg::ST_SCAN;
                        n_ptr   = '0;
                        n_first = 1'b1;
                    end
                end
            end
            sed_pkg::ST_SCAN: begin
                // walk up to the first request above the start cylinder
                if ((r_ptr < i_count) && (i_rd_cyl <= i_start_cyl)) begin
                    n_ptr = r_ptr + CNT_W'(1);
                end else begin
                    n_below = r_ptr;
                    n_state = (r_ptr != '0) ? sed_pkg::ST_DOWN : sed_pkg::ST_TURN;
                end
            end
            sed_pkg::ST_DOWN: begin
                o_rd_idx     = r_ptr - CNT_W'(1);
                n_stop.valid = 1'b1;
                n_stop.first = r_first;
                n_stop.cyl   = i_rd_cyl;
                n_first      = 1'b0;
                n_ptr        = r_ptr - CNT_W'(1);
                if (r_ptr == CNT_W'(1)) begin
                    n_state = sed_pkg::ST_TURN;
                end
            end
            sed_pkg::ST_TURN: begin
                n_stop.valid = 1'b1;
                n_stop.first = r_first;
                n_stop.cyl   = '0;
                n_stop.last  = (r_below == i_count);
                n_first      = 1'b0;
                if (r_below == i_count) begin
                    n_state         = sed_pkg::ST_IDLE;
                    o_store_ctl.clr = 1'b1;
                end else begin
                    n_ptr   = r_below;
                    n_state = sed_pkg::ST_UP;
                end
            end
            sed_pkg::ST_UP: begin
                n_stop.valid = 1'b1;
                n_stop.first = r_first;
                n_stop.cyl   = i_rd_cyl;
                n_stop.last  = ((r_ptr + CNT_W'(1)) == i_count);
                n_first      = 1'b0;
                n_ptr        = r_ptr + CNT_W'(1);
                if ((r_ptr + CNT_W'(1)) == i_count) begin
                    n_state         = sed_pkg::ST_IDLE;
                    o_store_ctl.clr = 1'b1;
                end
            end
            default: begin
                n_state = sed_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sed_pkg::ST_IDLE;
            r_ptr   <= '0;
            r_below <= '0;
            r_first <= 1'b0;
            r_stop  <= '0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_below <= n_below;
            r_first <= n_first;
            r_stop  <= n_stop;
        end
    end

    // movement: the first stop of a batch starts from the start cylinder
    always_comb begin
        base_head = r_stop.first ? i_start_cyl : r_head;
        base_move = r_stop.first ? '0 : r_move;
        hop_len   = (r_stop.cyl > base_head) ? (r_stop.cyl - base_head)
                                              : (base_head - r_stop.cyl);
        move_sum  = {1'b0, base_move} + {2'b00, hop_len};
        move_sat  = move_sum[sed_pkg::MOVE_W] ? sed_pkg::MOVE_MAX
                                               : move_sum[sed_pkg::MOVE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (r_stop.valid) begin
            r_head <= r_stop.cyl;
            r_move <= move_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= '0;
        end else begin
            r_mv.valid <= r_stop.valid;
            r_mv.last  <= r_stop.last;
            r_mv.cyl   <= r_stop.cyl;
            r_mv.move  <= move_sat;
        end
    end

    // 11 x 4 bit product stays below the 15 bit ceiling
    assign seek_prod = sed_pkg::SEEK_W'(r_mv.move) * sed_pkg::SEEK_W'(i_cost);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_mv.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_served_cylinder <= r_mv.cyl;
        o_total_movement  <= r_mv.move;
        o_seek_time       <= seek_prod;
        o_final_stop      <= r_mv.last;
    end

endmodule

[bench/tb.sv]
// Self-checking testbench for the SCAN elevator disk scheduler.
`timescale 1ns / 1ps
module tb;

    localparam int QDEPTH    = 32;
    localparam int RANDOM_N  = 500;
    localparam int SETTLE    = 60;      // covers the deepest walk below start plus pipeline
    localparam int LIMIT     = 300000;  // cycles before the run is declared hung
    localparam int MOVE_SAT  = 2047;
    localparam int SEEK_SAT  = 32767;
    localparam int CYL_TOP   = (1 << sed_pkg::CYL_W) - 1;

    // One request as the sender presents it.
    typedef struct packed {
        logic [sed_pkg::CYL_W-1:0] cyl;
        logic                      last;
    } t_request;

    // One stop as the scheduler should report it.
    typedef struct packed {
        logic [sed_pkg::CYL_W-1:0]  cyl;
        logic [sed_pkg::MOVE_W-1:0] move;
        logic [sed_pkg::SEEK_W-1:0] seek;
        logic                       last;
    } t_stop_due;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    logic [sed_pkg::CYL_W-1:0]      i_request_cylinder = '0;
    logic                           i_batch_end = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [sed_pkg::CFG_IDX_W-1:0]  i_cfg_index = sed_pkg::REG_START_CYL;
    logic [sed_pkg::CFG_W-1:0]      i_cfg_wdata = '0;
    logic                           o_valid;
    logic [sed_pkg::CYL_W-1:0]      o_served_cylinder;
    logic [sed_pkg::MOVE_W-1:0]     o_total_movement;
    logic [sed_pkg::SEEK_W-1:0]     o_seek_time;
    logic                           o_final_stop;

    scan_elevator_disk_scheduler DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_request_cylinder (i_request_cylinder),
        .i_batch_end        (i_batch_end),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata),
        .o_valid            (o_valid),
        .o_served_cylinder  (o_served_cylinder),
        .o_total_movement   (o_total_movement),
        .o_seek_time        (o_seek_time),
        .o_final_stop       (o_final_stop)
    );

    always #1 i_clk = ~i_clk;

    // Requests waiting for the driver, and the stops the scheduler still owes.
    t_request  requests_pending[$];
    t_stop_due scan_stops_due[$];

    // Shadow of the scheduler: configuration and the sorted request store.
    logic [sed_pkg::CYL_W-1:0]  cfg_start = sed_pkg::RESET_START;
    logic [sed_pkg::COST_W-1:0] cfg_cost  = sed_pkg::RESET_COST;
    logic [sed_pkg::CYL_W-1:0]  sorted_requests[QDEPTH];
    int                held_count = 0;
    int                head_pos;
    int                move_sum;

    // Bookkeeping for the summary and the verdict.
    int errors = 0;
    int requests_queued = 0;
    int requests_accepted = 0;
    int requests_dropped = 0;
    int batches_served = 0;
    int stops_checked = 0;
    int settings_used = 1;
    int cycle_count = 0;

    // Driver state.
    t_request  cur_request;
    int        burst_left = 1;
    int        gap_left = 0;
    t_stop_due due;

    // Move the head to cyl, accumulate movement with saturation, and queue the stop.
    function automatic void queue_stop(logic [sed_pkg::CYL_W-1:0] cyl, logic last);
        t_stop_due s;
        int        seek;
        move_sum += (int'(cyl) > head_pos) ? int'(cyl) - head_pos : head_pos - int'(cyl);
        if (move_sum > MOVE_SAT)
            move_sum = MOVE_SAT;
        head_pos = cyl;
        seek = move_sum * int'(cfg_cost);
        if (seek > SEEK_SAT)
            seek = SEEK_SAT;
        s.cyl  = cyl;
        s.move = move_sum[sed_pkg::MOVE_W-1:0];
        s.seek = seek[sed_pkg::SEEK_W-1:0];
        s.last = last;
        scan_stops_due = {scan_stops_due, s};
    endfunction

    // Insert one accepted request; on the batch end, work out the full sweep.
    function automatic void schedule_request(t_request rq);
        int i;
        int below;
        if (held_count >= QDEPTH) begin
            requests_dropped++;
        end else begin
            i = held_count;
            while (i > 0 && sorted_requests[i-1] > rq.cyl) begin
                sorted_requests[i] = sorted_requests[i-1];
                i--;
            end
            sorted_requests[i] = rq.cyl;
            held_count++;
        end
        if (!rq.last)
            return;
        head_pos = cfg_start;
        move_sum = 0;
        below = 0;
        while (below < held_count && sorted_requests[below] <= cfg_start)
            below++;
        // Sweep down through everything at or below the start, falling order.
        for (i = below - 1; i >= 0; i--)
            queue_stop(sorted_requests[i], 1'b0);
        // Turnaround at cylinder 0 is always reported; final if nothing lies above.
        queue_stop('0, below == held_count);
        for (i = below; i < held_count; i++)
            queue_stop(sorted_requests[i], i == held_count - 1);
        held_count = 0;
        batches_served++;
    endfunction

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // Pick the shape of the next burst: sometimes a long stretch with no idling.
    function automatic void plan_burst();
        if ($urandom_range(3) == 0) begin
            burst_left = $urandom_range(60, 20);
            gap_left   = 0;
        end else begin
            burst_left = $urandom_range(8, 1);
            gap_left   = $urandom_range(6, 1);
        end
    endfunction

    // Driver: hold start while busy, predict on acceptance, then present the next item.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                schedule_request(cur_request);
                requests_accepted++;
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (requests_pending.size() > 0) begin
                    cur_request = requests_pending.pop_front();
                    start <= 1'b1;
                    i_request_cylinder <= cur_request.cyl;
                    i_batch_end <= cur_request.last;
                    if (burst_left > 1)
                        burst_left--;
                    else
                        plan_burst();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed stop must match the oldest stop still due.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (scan_stops_due.size() == 0) begin
                $error("stop at cylinder %0d with none due", o_served_cylinder);
                errors++;
            end else begin
                due = scan_stops_due.pop_front();
                check_field("served_cylinder", due.cyl, o_served_cylinder);
                check_field("total_movement", due.move, o_total_movement);
                check_field("seek_time", due.seek, o_seek_time);
                check_field("final_stop", due.last, o_final_stop);
                stops_checked++;
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic void add_request(int cyl, bit last);
        t_request rq;
        rq.cyl  = cyl[sed_pkg::CYL_W-1:0];
        rq.last = last;
        requests_pending = {requests_pending, rq};
        requests_queued++;
    endfunction

    // Write one register; the shadow copy takes the masked value.
    task automatic cfg_write(logic [sed_pkg::CFG_IDX_W-1:0] idx,
                             logic [sed_pkg::CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        if (idx == sed_pkg::REG_START_CYL)
            cfg_start = data[sed_pkg::CYL_W-1:0];
        else
            cfg_cost = data[sed_pkg::COST_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every item is taken and every stop has come, then let the block settle.
    task automatic drain();
        while (requests_pending.size() > 0 || start || scan_stops_due.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Favor the interesting cylinders: both ends, the start itself and repeats.
    function automatic int pick_cylinder(int prev);
        case ($urandom_range(9))
            0: return 0;
            1: return CYL_TOP;
            2: return int'(cfg_start);
            3: return prev;
            default: return $urandom_range(CYL_TOP);
        endcase
    endfunction

    initial begin
        int          phase;
        int          nbatch;
        int          size;
        int          r;
        int          prev;
        logic [9:0]  new_start;
        logic [3:0]  new_cost;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset setting: start 100, cost 5.
        add_request(100, 1);            // lone request at the start, nothing above
        add_request(0, 0);              // equal requests, a request at 0, both ends
        add_request(1023, 0);
        add_request(100, 0);
        add_request(100, 0);
        add_request(50, 1);
        drain();

        // Lowest setting: start at 0 and free seeks.
        cfg_write(sed_pkg::REG_START_CYL, 10'd0);
        cfg_write(sed_pkg::REG_COST, 10'd0);
        settings_used++;
        add_request(0, 0);
        add_request(0, 0);
        add_request(5, 1);
        drain();

        // Highest setting: start at the top, dearest seeks, nothing above the start.
        cfg_write(sed_pkg::REG_START_CYL, 10'd1023);
        cfg_write(sed_pkg::REG_COST, 10'h3FF);
        settings_used++;
        add_request(1023, 0);
        add_request(512, 0);
        add_request(1, 1);
        drain();

        // Random phases: new setting each time, a handful of batches per phase.
        phase = 0;
        prev  = 0;
        while (requests_queued < RANDOM_N + 12) begin
            r = $urandom_range(4);
            new_start = (r == 0) ? 10'd0 : (r == 1) ? 10'd1023 : 10'($urandom);
            r = $urandom_range(4);
            new_cost = (r == 0) ? 4'd0 : (r == 1) ? 4'd15 : 4'($urandom);
            cfg_write(sed_pkg::REG_START_CYL, new_start);
            cfg_write(sed_pkg::REG_COST, {6'($urandom), new_cost});
            settings_used++;
            nbatch = $urandom_range(6, 2);
            for (int b = 0; b < nbatch; b++) begin
                r = $urandom_range(99);
                if (phase == 0 && b == 0)
                    size = QDEPTH + 2;      // overflow the store on purpose
                else if (r < 75)
                    size = $urandom_range(8, 1);
                else if (r < 93)
                    size = $urandom_range(QDEPTH - 1, 9);
                else
                    size = $urandom_range(QDEPTH + 4, QDEPTH);
                for (int k = 0; k < size; k++) begin
                    prev = pick_cylinder(prev);
                    add_request(prev, k == size - 1);
                end
            end
            drain();
            phase++;
        end

        drain();
        if (scan_stops_due.size() != 0) begin
            $error("%0d stops never reported", scan_stops_due.size());
            errors++;
        end
        $display("Covered %0d requests in %0d batches over %0d settings, %0d dropped.",
                 requests_accepted, batches_served, settings_used, requests_dropped);
        $display("Checked %0d stops in scan order, %0d errors.", stops_checked, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
